FILE: design/rcls_pkg.sv
// Shared constants for the RGB cosine and length similarity unit.
package rcls_pkg;

    localparam int SCORE_W      = 10;
    localparam int SEARCH_STEPS = 10;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1000;
    localparam int SCORE_SCALE    = 1000;
    localparam int SCORE_SCALE_SQ = 1000000;

endpackage

FILE: design/rgb_cosine_length_similarity_unit.sv
// Pipelined RGB cosine and length similarity scorer with exact integer scores.
//
// channel | signals                                          | direction
// --------+--------------------------------------------------+----------
// input   | in_valid, in_ready, a_red..a_blue, b_red..b_blue | into block
// output  | out_valid, out_ready, cosine_score, length_score,| out of block
//         | zero_vector                                      |
//
// One transaction per cycle while the output is not stalled; 4 arithmetic
// stages, then one shift-and-add search stage per score bit, 10 of them.
// Reset clears only the valid bits of the pipeline.
// When the output holds an unaccepted result the whole pipeline stalls
// and in_ready drops; bubbles inside the pipeline are not squeezed out.
module rgb_cosine_length_similarity_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CHANNEL_BITS-1:0]     a_red,
    input  logic [CHANNEL_BITS-1:0]     a_green,
    input  logic [CHANNEL_BITS-1:0]     a_blue,
    input  logic [CHANNEL_BITS-1:0]     b_red,
    input  logic [CHANNEL_BITS-1:0]     b_green,
    input  logic [CHANNEL_BITS-1:0]     b_blue,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rcls_pkg::SCORE_W-1:0] cosine_score,
    output logic [rcls_pkg::SCORE_W-1:0] length_score,
    output logic                        zero_vector
);
    import rcls_pkg::*;

    localparam int SQ_W = 2 * CHANNEL_BITS;
    localparam int NW   = 2 * CHANNEL_BITS + 2;   // norms and dot product
    localparam int DW   = NW + 10;                // 1000 * dot
    localparam int CW   = 2 * NW + 20;            // cosine compare width
    localparam int LW   = NW + 20;                // length compare width

    logic en;

    // stage 1: channel products
    logic            v1_reg;
    logic [SQ_W-1:0] aa_reg [0:2];
    logic [SQ_W-1:0] bb_reg [0:2];
    logic [SQ_W-1:0] ab_reg [0:2];

    // stage 2: sums
    logic          v2_reg;
    logic [NW-1:0] na_reg, nb_reg, dot_reg;

    // stage 3: product of norms, scaled dot, length operands
    logic          v3_reg;
    logic          z3_reg;
    logic [CW-1:0] p3_reg;
    logic [DW-1:0] d3_reg;
    logic [LW-1:0] pl3_reg, rl3_reg;

    // search pipeline, entry 0 is stage 4
    logic               sv_reg [0:SEARCH_STEPS];
    logic               sz_reg [0:SEARCH_STEPS];
    logic [CW-1:0]      p_reg  [0:SEARCH_STEPS];
    logic [CW-1:0]      r_reg  [0:SEARCH_STEPS];
    logic [CW-1:0]      t_reg  [0:SEARCH_STEPS];
    logic [CW-1:0]      q_reg  [0:SEARCH_STEPS];
    logic [SCORE_W-1:0] k_reg  [0:SEARCH_STEPS];
    logic [LW-1:0]      pl_reg [0:SEARCH_STEPS];
    logic [LW-1:0]      rl_reg [0:SEARCH_STEPS];
    logic [LW-1:0]      tl_reg [0:SEARCH_STEPS];
    logic [LW-1:0]      ql_reg [0:SEARCH_STEPS];
    logic [SCORE_W-1:0] kl_reg [0:SEARCH_STEPS];

    assign en       = !sv_reg[SEARCH_STEPS] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg[0] <= SQ_W'(a_red) * SQ_W'(a_red);
            aa_reg[1] <= SQ_W'(a_green) * SQ_W'(a_green);
            aa_reg[2] <= SQ_W'(a_blue) * SQ_W'(a_blue);
            bb_reg[0] <= SQ_W'(b_red) * SQ_W'(b_red);
            bb_reg[1] <= SQ_W'(b_green) * SQ_W'(b_green);
            bb_reg[2] <= SQ_W'(b_blue) * SQ_W'(b_blue);
            ab_reg[0] <= SQ_W'(a_red) * SQ_W'(b_red);
            ab_reg[1] <= SQ_W'(a_green) * SQ_W'(b_green);
            ab_reg[2] <= SQ_W'(a_blue) * SQ_W'(b_blue);

            na_reg  <= NW'(aa_reg[0]) + NW'(aa_reg[1]) + NW'(aa_reg[2]);
            nb_reg  <= NW'(bb_reg[0]) + NW'(bb_reg[1]) + NW'(bb_reg[2]);
            dot_reg <= NW'(ab_reg[0]) + NW'(ab_reg[1]) + NW'(ab_reg[2]);

            z3_reg <= (na_reg == '0) || (nb_reg == '0);
            p3_reg <= CW'(na_reg) * CW'(nb_reg);
            d3_reg <= DW'(dot_reg) * DW'(SCORE_SCALE);
            if (na_reg <= nb_reg)
            begin
                pl3_reg <= LW'(nb_reg);
                rl3_reg <= LW'(na_reg) * LW'(SCORE_SCALE_SQ);
            end
            else
            begin
                pl3_reg <= LW'(na_reg);
                rl3_reg <= LW'(nb_reg) * LW'(SCORE_SCALE_SQ);
            end

            sz_reg[0] <= z3_reg;
            p_reg[0]  <= p3_reg;
            r_reg[0]  <= CW'(d3_reg) * CW'(d3_reg);
            t_reg[0]  <= '0;
            q_reg[0]  <= '0;
            k_reg[0]  <= '0;
            pl_reg[0] <= pl3_reg;
            rl_reg[0] <= rl3_reg;
            tl_reg[0] <= '0;
            ql_reg[0] <= '0;
            kl_reg[0] <= '0;
        end
    end

    // One score bit per stage, MSB first. With Q = k*P and T = k^2*P,
    // (k + 2^b)^2 * P = T + (Q << (b+1)) + (P << 2b): no multiplier needed.
    genvar gi;
    generate
        for (gi = 0; gi < SEARCH_STEPS; gi++)
        begin : g_step
            localparam int B = SEARCH_STEPS - 1 - gi;
            logic [SCORE_W-1:0] ck_next, ckl_next;
            logic [CW-1:0]      ct_next;
            logic [LW-1:0]      ctl_next;
            logic               ok_next, okl_next;

            always_comb
            begin
                ck_next  = k_reg[gi] | SCORE_W'(1 << B);
                ct_next  = t_reg[gi] + (q_reg[gi] << (B + 1)) + (p_reg[gi] << (2 * B));
                ok_next  = (ck_next <= SCORE_MAX) && (ct_next <= r_reg[gi]);
                ckl_next = kl_reg[gi] | SCORE_W'(1 << B);
                ctl_next = tl_reg[gi] + (ql_reg[gi] << (B + 1))
                           + (pl_reg[gi] << (2 * B));
                okl_next = (ckl_next <= SCORE_MAX) && (ctl_next <= rl_reg[gi]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[gi+1] <= 1'b0;
                else if (en)
                    sv_reg[gi+1] <= sv_reg[gi];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sz_reg[gi+1] <= sz_reg[gi];
                    p_reg[gi+1]  <= p_reg[gi];
                    r_reg[gi+1]  <= r_reg[gi];
                    pl_reg[gi+1] <= pl_reg[gi];
                    rl_reg[gi+1] <= rl_reg[gi];
                    k_reg[gi+1]  <= ok_next ? ck_next : k_reg[gi];
                    t_reg[gi+1]  <= ok_next ? ct_next : t_reg[gi];
                    q_reg[gi+1]  <= ok_next ? q_reg[gi] + (p_reg[gi] << B) : q_reg[gi];
                    kl_reg[gi+1] <= okl_next ? ckl_next : kl_reg[gi];
                    tl_reg[gi+1] <= okl_next ? ctl_next : tl_reg[gi];
                    ql_reg[gi+1] <= okl_next ? ql_reg[gi] + (pl_reg[gi] << B)
                                             : ql_reg[gi];
                end
            end
        end
    endgenerate

    assign out_valid    = sv_reg[SEARCH_STEPS];
    assign zero_vector  = sz_reg[SEARCH_STEPS];
    assign cosine_score = sz_reg[SEARCH_STEPS] ? '0 : k_reg[SEARCH_STEPS];
    assign length_score = sz_reg[SEARCH_STEPS] ? '0 : kl_reg[SEARCH_STEPS];

endmodule

FILE: bench/tb.sv
// Self-checking bench for the RGB cosine and length similarity unit.
module tb;
    import rcls_pkg::*;

    localparam int CB = 8;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [SCORE_W-1:0] cosine;
        logic [SCORE_W-1:0] length;
        logic               zero;
    } score_t;

    class score_board;
        score_t pending[$];
        int     errors;
        int     checked;
        int     zeros;
        int     perfect;

        // Largest k in 0..1000 with k^2*den <= num, all in wide integers.
        function logic [SCORE_W-1:0] largest_k(logic [127:0] num,
                                               logic [127:0] den);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = SCORE_SCALE;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (128'(mid) * 128'(mid) * den <= num)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return SCORE_W'(lo);
        endfunction

        function void note_input(logic [CB-1:0] ar, logic [CB-1:0] ag,
                                 logic [CB-1:0] ab, logic [CB-1:0] br,
                                 logic [CB-1:0] bg, logic [CB-1:0] bb);
            logic [127:0] na;
            logic [127:0] nb;
            logic [127:0] dp;
            score_t s;
            na = 128'(ar) * ar + 128'(ag) * ag + 128'(ab) * ab;
            nb = 128'(br) * br + 128'(bg) * bg + 128'(bb) * bb;
            dp = 128'(ar) * br + 128'(ag) * bg + 128'(ab) * bb;
            s = '0;
            if (na == 0 || nb == 0) begin
                s.zero = 1'b1;
            end
            else begin
                s.cosine = largest_k(dp * SCORE_SCALE * dp * SCORE_SCALE, na * nb);
                if (na <= nb)
                    s.length = largest_k(na * SCORE_SCALE_SQ, nb);
                else
                    s.length = largest_k(nb * SCORE_SCALE_SQ, na);
            end
            pending.push_back(s);
        endfunction

        function void check_result(logic [SCORE_W-1:0] c, logic [SCORE_W-1:0] l,
                                   logic z);
            score_t e;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.zero) zeros++;
            if (e.cosine == SCORE_MAX) perfect++;
            if (c !== e.cosine) begin
                $error("cosine_score expected %0d actual %0d", e.cosine, c);
                errors++;
            end
            if (l !== e.length) begin
                $error("length_score expected %0d actual %0d", e.length, l);
                errors++;
            end
            if (z !== e.zero) begin
                $error("zero_vector expected %0d actual %0d", e.zero, z);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [CB-1:0] a_red, a_green, a_blue, b_red, b_green, b_blue;
    logic out_valid;
    logic out_ready;
    logic [SCORE_W-1:0] cosine_score;
    logic [SCORE_W-1:0] length_score;
    logic zero_vector;

    score_board sb;
    bit  quiet_tail;
    bit  hold_sink;
    int  idle_cycles;
    int  sink_idle;
    int  sent;

    rgb_cosine_length_similarity_unit #(.CHANNEL_BITS(CB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_red(a_red), .a_green(a_green), .a_blue(a_blue),
        .b_red(b_red), .b_green(b_green), .b_blue(b_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .cosine_score(cosine_score), .length_score(length_score),
        .zero_vector(zero_vector)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_pair(logic [CB-1:0] ar, logic [CB-1:0] ag, logic [CB-1:0] ab,
                             logic [CB-1:0] br, logic [CB-1:0] bg, logic [CB-1:0] bb);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_red <= ar; a_green <= ag; a_blue <= ab;
        b_red <= br; b_green <= bg; b_blue <= bb;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_random;
        logic [CB-1:0] v[6];
        int k;
        for (int i = 0; i < 6; i++) v[i] = CB'($urandom);
        case ($urandom_range(0, 9))
            0: begin  // b a scaled copy of a, expect a perfect cosine
                k = $urandom_range(1, 4);
                for (int i = 0; i < 3; i++) begin
                    v[i] = v[i] / CB'(k);
                    v[i+3] = v[i] * CB'(k);
                end
            end
            1: begin  // one side all zero
                k = $urandom_range(0, 1) * 3;
                v[k] = '0; v[k+1] = '0; v[k+2] = '0;
            end
            2: for (int i = 0; i < 6; i++) v[i] = CB'($urandom_range(0, 3));
            3: for (int i = 0; i < 6; i++) v[i] = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    // Result side: stall bursts of random length, one long hold, none in the tail.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(cosine_score, length_score, zero_vector);
            if (hold_sink)
                out_ready <= 1'b0;
            else if (!quiet_tail && sink_idle > 0) begin
                out_ready <= 1'b0;
                sink_idle <= sink_idle - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 12) == 0) begin
                out_ready <= 1'b0;
                sink_idle <= $urandom_range(0, 18);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // Predict on the accepted transaction itself.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            sb.note_input(a_red, a_green, a_blue, b_red, b_green, b_blue);

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {a_red, a_green, a_blue, b_red, b_green, b_blue} = '0;
        quiet_tail = 1'b0;
        hold_sink = 1'b0;
        idle_cycles = 0;
        sink_idle = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 255, 255, 255);
        send_pair(255, 255, 255, 0, 0, 0);
        send_pair(255, 255, 255, 255, 255, 255);
        send_pair(1, 1, 1, 1, 1, 1);
        send_pair(1, 0, 0, 255, 0, 0);
        send_pair(255, 0, 0, 0, 255, 0);
        send_pair(0, 0, 255, 0, 255, 0);
        send_pair(1, 0, 0, 0, 0, 1);
        send_pair(1, 0, 0, 255, 255, 255);
        send_pair(255, 255, 255, 1, 0, 0);
        send_pair(10, 20, 30, 20, 40, 60);
        send_pair(255, 254, 253, 1, 2, 3);
        send_pair(170, 85, 170, 85, 170, 85);
        send_pair(128, 64, 32, 127, 63, 31);

        // long receiver hold while the sender keeps pushing
        hold_sink = 1'b1;
        fork
            repeat (200) @(posedge clk);
            repeat (60) send_random();
        join_any
        hold_sink = 1'b0;
        wait fork;

        repeat (300) send_random();

        // sender pauses until the block drains
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);

        repeat (250) send_random();
        quiet_tail = 1'b1;
        repeat (80) send_random();
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0) sb.errors++;

        $display("Sent %0d pairs, checked %0d results (%0d zero-vector, %0d perfect cosine).",
                 sent, sb.checked, sb.zeros, sb.perfect);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
